// ----- hw/rtl/lzcp_pkg.sv -----
// Shared types and codes for the LZMA2 chunk header parser.
`timescale 1ns / 1ps

package lzcp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_HDR_DONE = 3'd1;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd2;
    localparam logic [2:0] KIND_LAST     = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;
    localparam logic [2:0] KIND_IGNORED  = 3'd6;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_CTRL  = 3'd1;
    localparam logic [2:0] ERR_SHORT_HDR = 3'd2;
    localparam logic [2:0] ERR_BAD_PROPS = 3'd3;
    localparam logic [2:0] ERR_SHORT_PAY = 3'd4;
    localparam logic [2:0] ERR_NO_PROPS  = 3'd5;

    // Control byte values and masks
    localparam logic [7:0] CTRL_END       = 8'h00;
    localparam logic [7:0] CTRL_RAW_DICT  = 8'h01;
    localparam logic [7:0] CTRL_RAW       = 8'h02;
    localparam logic [7:0] CTRL_LZMA_BIT  = 8'h80;
    localparam logic [7:0] PROPS_LIMIT    = 8'd225;
    localparam logic [3:0] LC_LP_MAX      = 4'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_out;
        logic        is_compressed;
        logic        dict_reset;
        logic        state_reset;
        logic        props_present;
        logic [21:0] unpacked_size;
        logic [16:0] packed_size;
        logic [3:0]  lc;
        logic [2:0]  lp;
        logic [2:0]  pb;
        logic [2:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [3:0] lc;
        logic [2:0] lp;
        logic [2:0] pb;
        logic       bad;
    } props_t;

endpackage

// ----- hw/rtl/lzcp_props_dec.sv -----
// Properties byte split into lc, lp and pb with range check.
`timescale 1ns / 1ps

module lzcp_props_dec (
    input  logic [7:0]      props_byte,
    output lzcp_pkg::props_t props
);
    import lzcp_pkg::*;

    logic [13:0] q9_prod;
    logic [4:0]  q9;
    logic [7:0]  lc_full;
    logic [8:0]  q5_prod;
    logic [2:0]  pb_val;
    logic [4:0]  lp_full;
    logic [3:0]  lc_lp_sum;

    // byte/9 by reciprocal 57/512, exact for bytes below 225
    assign q9_prod = 14'(props_byte) * 14'd57;
    assign q9      = q9_prod[13:9];
    assign lc_full = props_byte - 8'(q9) * 8'd9;
    // q9/5 by reciprocal 13/64, exact for q9 below 25
    assign q5_prod = 9'(q9) * 9'd13;
    assign pb_val  = q5_prod[8:6];
    assign lp_full = q9 - 5'(pb_val) * 5'd5;

    assign lc_lp_sum = lc_full[3:0] + {1'b0, lp_full[2:0]};

    assign props.lc  = lc_full[3:0];
    assign props.lp  = lp_full[2:0];
    assign props.pb  = pb_val;
    assign props.bad = (props_byte >= PROPS_LIMIT) || (lc_lp_sum > LC_LP_MAX);

endmodule

// ----- hw/rtl/lzma2_chunk_header_parser.sv -----
// Top level: LZMA2 chunk header parser, one stream byte per item.
`timescale 1ns / 1ps

// Channel | Handshake          | Payload
// in      | in_valid/in_ready   | data_byte, end_of_data
// out     | out_valid/out_ready | kind, byte_out, flags, sizes, props, error_code
//
// One item per cycle while the output is not stalled; each accepted byte yields one result in the cycle after.
// The result register is the only stage; parse state updates on acceptance.
// in_ready drops only while a result waits and out_ready is low.
// Reset clears parse state, saved properties and the halt flag.

module lzma2_chunk_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  byte_out,
    output logic        is_compressed,
    output logic        dict_reset,
    output logic        state_reset,
    output logic        props_present,
    output logic [21:0] unpacked_size,
    output logic [16:0] packed_size,
    output logic [3:0]  literal_context_bits,
    output logic [2:0]  literal_position_bits,
    output logic [2:0]  position_bits,
    output logic [2:0]  error_code
);
    import lzcp_pkg::*;

    typedef enum logic [2:0] {
        PH_CTRL    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [3:0]  flags_reg, flags_next;     // {props, state, dict, comp}
    logic [21:0] unpacked_reg, unpacked_next;
    logic [16:0] packed_reg, packed_next;
    logic [21:0] remain_reg, remain_next;
    logic [3:0]  lc_reg, lc_next;
    logic [2:0]  lp_reg, lp_next;
    logic [2:0]  pb_reg, pb_next;
    logic        props_ok_reg, props_ok_next;
    logic        halted_reg, halted_next;
    logic        out_valid_reg;
    result_t     res_reg, res_next;

    props_t      props;
    logic        accept;
    logic [2:0]  idx;
    logic [2:0]  need;
    logic [21:0] remain_dec;
    logic [2:0]  lvl;

    lzcp_props_dec u_props (
        .props_byte (data_byte),
        .props      (props)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign idx        = hdr_idx_reg + 3'd1;
    assign need       = flags_reg[0] ? (flags_reg[3] ? 3'd5 : 3'd4) : 3'd2;
    assign remain_dec = (remain_reg != '0) ? remain_reg - 22'd1 : '0;
    assign lvl        = {1'b0, data_byte[6:5]};

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        flags_next    = flags_reg;
        unpacked_next = unpacked_reg;
        packed_next   = packed_reg;
        remain_next   = remain_reg;
        lc_next       = lc_reg;
        lp_next       = lp_reg;
        pb_next       = pb_reg;
        props_ok_next = props_ok_reg;
        halted_next   = halted_reg;
        res_next      = '0;

        if (halted_reg)
        begin
            res_next.kind = KIND_IGNORED;
        end
        else
        begin
            case (phase_reg)
                PH_CTRL:
                begin
                    if (data_byte == CTRL_END)
                    begin
                        halted_next   = 1'b1;
                        res_next.kind = KIND_END;
                    end
                    else if ((data_byte & CTRL_LZMA_BIT) == '0 &&
                             data_byte != CTRL_RAW_DICT && data_byte != CTRL_RAW)
                    begin
                        halted_next         = 1'b1;
                        res_next.kind       = KIND_ERROR;
                        res_next.error_code = ERR_BAD_CTRL;
                    end
                    else
                    begin
                        packed_next = '0;
                        if (data_byte[7])
                        begin
                            flags_next    = {lvl >= 3'd2, lvl >= 3'd1, lvl == 3'd3, 1'b1};
                            unpacked_next = {1'b0, data_byte[4:0], 16'h0000};
                        end
                        else
                        begin
                            flags_next    = {2'b00, data_byte == CTRL_RAW_DICT, 1'b0};
                            unpacked_next = '0;
                        end
                        if (end_of_data)
                        begin
                            halted_next         = 1'b1;
                            res_next.kind       = KIND_ERROR;
                            res_next.error_code = ERR_SHORT_HDR;
                        end
                        else
                        begin
                            hdr_idx_next           = '0;
                            phase_next             = PH_HEADER;
                            res_next.kind          = KIND_HEADER;
                            res_next.is_compressed = flags_next[0];
                            res_next.dict_reset    = flags_next[1];
                            res_next.state_reset   = flags_next[2];
                            res_next.props_present = flags_next[3];
                        end
                    end
                end
                PH_HEADER:
                begin
                    hdr_idx_next = idx;
                    case (idx)
                        3'd1: unpacked_next = unpacked_reg | {6'd0, data_byte, 8'd0};
                        3'd2: unpacked_next = unpacked_reg | {14'd0, data_byte};
                        3'd3: packed_next   = {1'b0, data_byte, 8'd0};
                        3'd4: packed_next   = packed_reg | {9'd0, data_byte};
                        default: ;
                    endcase
                    res_next.is_compressed = flags_reg[0];
                    res_next.dict_reset    = flags_reg[1];
                    res_next.state_reset   = flags_reg[2];
                    res_next.props_present = flags_reg[3];
                    if (idx < need)
                    begin
                        if (end_of_data)
                        begin
                            halted_next         = 1'b1;
                            res_next            = '0;
                            res_next.kind       = KIND_ERROR;
                            res_next.error_code = ERR_SHORT_HDR;
                        end
                        else
                        begin
                            res_next.kind = KIND_HEADER;
                        end
                    end
                    else if ((need == 3'd5 && props.bad) || end_of_data ||
                             (flags_reg[0] && !flags_reg[3] && !props_ok_reg))
                    begin
                        halted_next   = 1'b1;
                        res_next      = '0;
                        res_next.kind = KIND_ERROR;
                        if (need == 3'd5 && props.bad)
                            res_next.error_code = ERR_BAD_PROPS;
                        else if (end_of_data)
                            res_next.error_code = ERR_SHORT_PAY;
                        else
                            res_next.error_code = ERR_NO_PROPS;
                    end
                    else
                    begin
                        if (flags_reg[3])
                        begin
                            lc_next       = props.lc;
                            lp_next       = props.lp;
                            pb_next       = props.pb;
                            props_ok_next = 1'b1;
                        end
                        unpacked_next = unpacked_next + 22'd1;
                        if (flags_reg[0])
                        begin
                            packed_next = packed_next + 17'd1;
                            remain_next = {5'd0, packed_next};
                        end
                        else
                        begin
                            remain_next = unpacked_next;
                        end
                        phase_next             = PH_PAYLOAD;
                        res_next.kind          = KIND_HDR_DONE;
                        res_next.unpacked_size = unpacked_next;
                        if (flags_reg[0])
                        begin
                            res_next.packed_size = packed_next;
                            res_next.lc          = lc_next;
                            res_next.lp          = lp_next;
                            res_next.pb          = pb_next;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    remain_next = remain_dec;
                    if (remain_dec != '0 && end_of_data)
                    begin
                        halted_next         = 1'b1;
                        res_next.kind       = KIND_ERROR;
                        res_next.error_code = ERR_SHORT_PAY;
                    end
                    else
                    begin
                        res_next.kind          = (remain_dec == '0) ? KIND_LAST : KIND_PAYLOAD;
                        res_next.byte_out      = data_byte;
                        res_next.is_compressed = flags_reg[0];
                        res_next.dict_reset    = flags_reg[1];
                        res_next.state_reset   = flags_reg[2];
                        res_next.props_present = flags_reg[3];
                        res_next.unpacked_size = unpacked_reg;
                        if (flags_reg[0])
                        begin
                            res_next.packed_size = packed_reg;
                            res_next.lc          = lc_reg;
                            res_next.lp          = lp_reg;
                            res_next.pb          = pb_reg;
                        end
                        if (remain_dec == '0)
                            phase_next = PH_CTRL;
                    end
                end
                default:
                begin
                    phase_next = PH_CTRL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CTRL;
            hdr_idx_reg   <= '0;
            flags_reg     <= '0;
            unpacked_reg  <= '0;
            packed_reg    <= '0;
            remain_reg    <= '0;
            lc_reg        <= '0;
            lp_reg        <= '0;
            pb_reg        <= '0;
            props_ok_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                hdr_idx_reg  <= hdr_idx_next;
                flags_reg    <= flags_next;
                unpacked_reg <= unpacked_next;
                packed_reg   <= packed_next;
                remain_reg   <= remain_next;
                lc_reg       <= lc_next;
                lp_reg       <= lp_next;
                pb_reg       <= pb_next;
                props_ok_reg <= props_ok_next;
                halted_reg   <= halted_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_valid             = out_valid_reg;
    assign kind                  = res_reg.kind;
    assign byte_out              = res_reg.byte_out;
    assign is_compressed         = res_reg.is_compressed;
    assign dict_reset            = res_reg.dict_reset;
    assign state_reset           = res_reg.state_reset;
    assign props_present         = res_reg.props_present;
    assign unpacked_size         = res_reg.unpacked_size;
    assign packed_size           = res_reg.packed_size;
    assign literal_context_bits  = res_reg.lc;
    assign literal_position_bits = res_reg.lp;
    assign position_bits         = res_reg.pb;
    assign error_code            = res_reg.error_code;

endmodule

// ----- hw/rtl/lzcp_checker.sv -----
// Port-level checks for the LZMA2 chunk header parser, bound to the top level.
`timescale 1ns / 1ps

module lzcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [21:0] unpacked_size,
    input logic [16:0] packed_size,
    input logic [2:0]  error_code
);
    import lzcp_pkg::*;

    // Stall only while a result waits on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a pending result");

    // A result waiting on a stalled output holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(error_code)))
        else $error("pending result changed");

    // Error code appears on error results only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // Chunk-done and payload results carry a nonzero unpacked size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_HDR_DONE || kind == KIND_PAYLOAD || kind == KIND_LAST))
            |-> (unpacked_size != '0))
        else $error("chunk result without unpacked size");

    // End, error and ignored results carry no sizes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_END || kind == KIND_ERROR || kind == KIND_IGNORED))
            |-> (unpacked_size == '0 && packed_size == '0))
        else $error("sizes on a terminal result");

endmodule

bind lzma2_chunk_header_parser lzcp_checker u_lzcp_checker (.*);

// ----- dv/lzcp_scoreboard_pkg.sv -----
// Scoreboard class that predicts and checks the chunk header parser results.
`timescale 1ns / 1ps

package lzcp_scoreboard_pkg;

    import lzcp_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_CTRL,
        IN_HEADER,
        IN_PAYLOAD
    } parse_phase_e;

    class chunk_scoreboard;

        parse_phase_e phase;
        logic [2:0]   hdr_idx;
        logic         comp;
        logic         dict;
        logic         state_rst;
        logic         has_props;
        logic [21:0]  unpacked_cnt;
        logic [16:0]  packed_cnt;
        logic [21:0]  bytes_left;
        logic [3:0]   kept_lc;
        logic [2:0]   kept_lp;
        logic [2:0]   kept_pb;
        logic         props_kept;
        logic         stopped;
        result_t      expected_q[$];
        int unsigned  mismatches;
        int unsigned  results_seen;

        function new();
            phase        = AWAIT_CTRL;
            hdr_idx      = '0;
            comp         = 1'b0;
            dict         = 1'b0;
            state_rst    = 1'b0;
            has_props    = 1'b0;
            unpacked_cnt = '0;
            packed_cnt   = '0;
            bytes_left   = '0;
            kept_lc      = '0;
            kept_lp      = '0;
            kept_pb      = '0;
            props_kept   = 1'b0;
            stopped      = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            expected_q.push_back(parse_byte(b, eod));
        endfunction

        function result_t stop_with(logic [2:0] code);
            result_t r;
            r            = '0;
            r.kind       = KIND_ERROR;
            r.error_code = code;
            stopped      = 1'b1;
            return r;
        endfunction

        function result_t with_flags(result_t r);
            r.is_compressed = comp;
            r.dict_reset    = dict;
            r.state_reset   = state_rst;
            r.props_present = has_props;
            return r;
        endfunction

        function result_t with_chunk(result_t r);
            r               = with_flags(r);
            r.unpacked_size = unpacked_cnt;
            if (comp)
            begin
                r.packed_size = packed_cnt;
                r.lc          = kept_lc;
                r.lp          = kept_lp;
                r.pb          = kept_pb;
            end
            return r;
        endfunction

        function result_t parse_byte(logic [7:0] b, logic eod);
            result_t r;
            int      need;
            int      nlc;
            int      nlp;
            int      npb;
            r   = '0;
            nlc = 0;
            nlp = 0;
            npb = 0;
            if (stopped)
            begin
                r.kind = KIND_IGNORED;
                return r;
            end

            if (phase == AWAIT_CTRL)
            begin
                if (b == CTRL_END)
                begin
                    stopped = 1'b1;
                    r.kind  = KIND_END;
                    return r;
                end
                packed_cnt = '0;
                if (b == CTRL_RAW_DICT || b == CTRL_RAW)
                begin
                    comp         = 1'b0;
                    dict         = (b == CTRL_RAW_DICT);
                    state_rst    = 1'b0;
                    has_props    = 1'b0;
                    unpacked_cnt = '0;
                end
                else if ((b & CTRL_LZMA_BIT) != 0)
                begin
                    // reset level sits in bits 6:5, size bits 20:16 below it
                    comp         = 1'b1;
                    state_rst    = (b[6:5] != 2'd0);
                    has_props    = b[6];
                    dict         = (b[6:5] == 2'd3);
                    unpacked_cnt = {1'b0, b[4:0], 16'h0000};
                end
                else
                begin
                    return stop_with(ERR_BAD_CTRL);
                end
                if (eod)
                    return stop_with(ERR_SHORT_HDR);
                hdr_idx = '0;
                phase   = IN_HEADER;
                r.kind  = KIND_HEADER;
                return with_flags(r);
            end

            if (phase == IN_HEADER)
            begin
                hdr_idx = hdr_idx + 3'd1;
                need    = comp ? (has_props ? 5 : 4) : 2;
                case (hdr_idx)
                    3'd1: unpacked_cnt[15:8] = b;
                    3'd2: unpacked_cnt[7:0] = b;
                    3'd3: packed_cnt = {1'b0, b, 8'h00};
                    3'd4: packed_cnt[7:0] = b;
                    default: ;
                endcase
                if (hdr_idx < need)
                begin
                    if (eod)
                        return stop_with(ERR_SHORT_HDR);
                    r.kind = KIND_HEADER;
                    return with_flags(r);
                end
                if (need == 5)
                begin
                    if (b >= PROPS_LIMIT)
                        return stop_with(ERR_BAD_PROPS);
                    nlc = b % 9;
                    nlp = (b / 9) % 5;
                    npb = b / 45;
                    if (nlc + nlp > LC_LP_MAX)
                        return stop_with(ERR_BAD_PROPS);
                end
                if (eod)
                    return stop_with(ERR_SHORT_PAY);
                if (comp && !has_props && !props_kept)
                    return stop_with(ERR_NO_PROPS);
                if (has_props)
                begin
                    kept_lc    = nlc[3:0];
                    kept_lp    = nlp[2:0];
                    kept_pb    = npb[2:0];
                    props_kept = 1'b1;
                end
                unpacked_cnt = unpacked_cnt + 22'd1;
                if (comp)
                begin
                    packed_cnt = packed_cnt + 17'd1;
                    bytes_left = {5'b0, packed_cnt};
                end
                else
                begin
                    bytes_left = unpacked_cnt;
                end
                phase  = IN_PAYLOAD;
                r.kind = KIND_HDR_DONE;
                return with_chunk(r);
            end

            if (bytes_left != 0)
                bytes_left = bytes_left - 22'd1;
            r.byte_out = b;
            r          = with_chunk(r);
            if (bytes_left == 0)
            begin
                phase  = AWAIT_CTRL;
                r.kind = KIND_LAST;
                return r;
            end
            if (eod)
                return stop_with(ERR_SHORT_PAY);
            r.kind = KIND_PAYLOAD;
            return r;
        endfunction

        function void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %0h, got %0h",
                         results_seen, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                flag_mismatch("unpredicted result, kind", 32'hffff_ffff, 32'(got.kind));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                flag_mismatch("kind", 32'(want.kind), 32'(got.kind));
            if (got.byte_out !== want.byte_out)
                flag_mismatch("byte_out", 32'(want.byte_out), 32'(got.byte_out));
            if (got.is_compressed !== want.is_compressed)
                flag_mismatch("is_compressed", 32'(want.is_compressed),
                              32'(got.is_compressed));
            if (got.dict_reset !== want.dict_reset)
                flag_mismatch("dict_reset", 32'(want.dict_reset), 32'(got.dict_reset));
            if (got.state_reset !== want.state_reset)
                flag_mismatch("state_reset", 32'(want.state_reset), 32'(got.state_reset));
            if (got.props_present !== want.props_present)
                flag_mismatch("props_present", 32'(want.props_present),
                              32'(got.props_present));
            if (got.unpacked_size !== want.unpacked_size)
                flag_mismatch("unpacked_size", 32'(want.unpacked_size),
                              32'(got.unpacked_size));
            if (got.packed_size !== want.packed_size)
                flag_mismatch("packed_size", 32'(want.packed_size), 32'(got.packed_size));
            if (got.lc !== want.lc)
                flag_mismatch("literal_context_bits", 32'(want.lc), 32'(got.lc));
            if (got.lp !== want.lp)
                flag_mismatch("literal_position_bits", 32'(want.lp), 32'(got.lp));
            if (got.pb !== want.pb)
                flag_mismatch("position_bits", 32'(want.pb), 32'(got.pb));
            if (got.error_code !== want.error_code)
                flag_mismatch("error_code", 32'(want.error_code), 32'(got.error_code));
        endfunction

    endclass

endpackage

// ----- dv/tb_lzma2_chunk_header_parser.sv -----
// Testbench top: random LZMA2 streams driven through the chunk header parser.
`timescale 1ns / 1ps

module tb_lzma2_chunk_header_parser;

    import lzcp_pkg::*;
    import lzcp_scoreboard_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int STREAM_ITEMS   = 1150;
    localparam int STEADY_FIRST   = 400;
    localparam int STEADY_LAST    = 700;
    localparam int IDLE_PCT       = 29;
    localparam int DRAIN_CYCLES   = 5;
    localparam int NOISE_ITEMS    = 16;
    localparam int MAX_CUT        = 40;
    localparam int RAW_DICT_CHUNK = 4;
    localparam int RAW_CHUNK      = 5;

    typedef enum int {
        END_MARKER,
        END_BAD_CTRL,
        END_SHORT_HDR,
        END_BAD_PROPS,
        END_SHORT_PAY,
        END_NO_PROPS
    } stream_end_e;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_data;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic        is_compressed;
    logic        dict_reset;
    logic        state_reset;
    logic        props_present;
    logic [21:0] unpacked_size;
    logic [16:0] packed_size;
    logic [3:0]  literal_context_bits;
    logic [2:0]  literal_position_bits;
    logic [2:0]  position_bits;
    logic [2:0]  error_code;

    logic [8:0]      stream_q[$];
    chunk_scoreboard sb;
    logic            steady;
    logic            rst_done;
    logic            props_seen;
    logic            lzma_ok;
    int unsigned     cycle_cnt = 0;

    lzma2_chunk_header_parser u_top (.*);

    always #HALF_PERIOD clk = ~clk;

    task automatic push_byte(input logic [7:0] b, input logic eod);
        stream_q.push_back({eod, b});
    endtask

    // Append one whole chunk; mode is an LZMA reset level or one of the raw modes.
    task automatic add_chunk(input int mode, input int unsigned usize,
                             input int unsigned psize, input logic [7:0] props,
                             input logic eod_last, output int hdr_len, output int pay_len);
        logic [20:0] u_m1;
        logic [15:0] p_m1;
        logic [1:0]  lvl;
        u_m1 = 21'(usize - 1);
        p_m1 = 16'(psize - 1);
        lvl  = mode[1:0];
        if (mode >= RAW_DICT_CHUNK)
        begin
            push_byte(mode == RAW_DICT_CHUNK ? CTRL_RAW_DICT : CTRL_RAW, 1'b0);
            push_byte(u_m1[15:8], 1'b0);
            push_byte(u_m1[7:0], 1'b0);
            hdr_len = 2;
            pay_len = u_m1[15:0] + 1;
        end
        else
        begin
            push_byte(CTRL_LZMA_BIT | {1'b0, lvl, u_m1[20:16]}, 1'b0);
            push_byte(u_m1[15:8], 1'b0);
            push_byte(u_m1[7:0], 1'b0);
            push_byte(p_m1[15:8], 1'b0);
            push_byte(p_m1[7:0], 1'b0);
            hdr_len = 4;
            if (lvl >= 2'd2)
            begin
                push_byte(props, 1'b0);
                hdr_len    = 5;
                props_seen = 1'b1;
            end
            pay_len = p_m1 + 1;
        end
        for (int i = 0; i < pay_len; i++)
            push_byte(8'($urandom_range(0, 255)), eod_last && (i == pay_len - 1));
    endtask

    // Mostly tiny chunks; wide ones take any size and are cut short by the caller.
    task automatic random_chunk(input logic wide, output int hdr_len, output int pay_len);
        int          mode;
        int          lc;
        int          lp;
        int unsigned size;
        lc = $urandom_range(0, 4);
        lp = $urandom_range(0, 4 - lc);
        if (wide)
            size = $urandom_range(1, 65536);
        else if ($urandom_range(0, 9) == 0)
            size = $urandom_range(1, 64);
        else
            size = $urandom_range(1, 6);
        if (!lzma_ok || $urandom_range(0, 9) < 3)
            mode = $urandom_range(RAW_DICT_CHUNK, RAW_CHUNK);
        else
            mode = props_seen ? $urandom_range(0, 3) : $urandom_range(2, 3);
        add_chunk(mode, mode >= RAW_DICT_CHUNK ? size : $urandom_range(1, 1 << 21), size,
                  8'(($urandom_range(0, 4) * 5 + lp) * 9 + lc),
                  !wide && ($urandom_range(0, 5) == 0), hdr_len, pay_len);
    endtask

    // Drop everything past keep bytes of the chunk that starts at start.
    task automatic cut_stream(input int start, input int keep, input logic eod);
        while (stream_q.size() > start + keep)
            void'(stream_q.pop_back());
        stream_q[stream_q.size() - 1][8] = eod;
    endtask

    task automatic build_stream();
        stream_end_e ending;
        int          start;
        int          hdr_len;
        int          pay_len;
        int          lc;
        int          lp;
        logic [7:0]  bad;
        ending     = stream_end_e'($urandom_range(0, 5));
        // a missing-properties chunk only fails before any properties were kept
        lzma_ok    = (ending != END_NO_PROPS);
        props_seen = 1'b0;

        add_chunk(RAW_DICT_CHUNK, 1, 1, 8'h00, 1'b0, hdr_len, pay_len);
        if (lzma_ok)
        begin
            // largest unpacked size, lp and pb at their maximum
            add_chunk(3, 1 << 21, 2, 8'd216, 1'b0, hdr_len, pay_len);
            // reuse kept properties; stream break right after the last payload byte
            add_chunk(0, 1, 1, 8'h00, 1'b1, hdr_len, pay_len);
            // lc at its maximum with pb 4
            add_chunk(2, 1 << 16, 1, 8'd184, 1'b0, hdr_len, pay_len);
            add_chunk(1, 300, 1, 8'h00, 1'b0, hdr_len, pay_len);
        end
        add_chunk(RAW_CHUNK, 2, 2, 8'h00, 1'b1, hdr_len, pay_len);

        while (stream_q.size() < STREAM_ITEMS)
            random_chunk(1'b0, hdr_len, pay_len);

        start = stream_q.size();
        case (ending)
            END_MARKER:
                push_byte(CTRL_END, 1'($urandom_range(0, 1)));
            END_BAD_CTRL:
                push_byte(8'($urandom_range(3, 127)), 1'($urandom_range(0, 1)));
            END_SHORT_HDR:
            begin
                random_chunk(1'b0, hdr_len, pay_len);
                cut_stream(start, $urandom_range(1, hdr_len), 1'b1);
            end
            END_BAD_PROPS:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    bad = 8'($urandom_range(PROPS_LIMIT, 255));
                end
                else
                begin
                    lc  = $urandom_range(1, 8);
                    lp  = $urandom_range(lc > 4 ? 0 : 5 - lc, 4);
                    bad = 8'(($urandom_range(0, 4) * 5 + lp) * 9 + lc);
                end
                add_chunk($urandom_range(2, 3), $urandom_range(1, 1 << 21),
                          $urandom_range(1, 6), bad, 1'b0, hdr_len, pay_len);
                cut_stream(start, hdr_len + 1, 1'($urandom_range(0, 1)));
            end
            END_SHORT_PAY:
            begin
                random_chunk(1'b1, hdr_len, pay_len);
                cut_stream(start, hdr_len + 1 +
                           $urandom_range(0, pay_len > MAX_CUT ? MAX_CUT : pay_len - 1), 1'b1);
            end
            default:
            begin
                add_chunk($urandom_range(0, 1), $urandom_range(1, 1 << 21),
                          $urandom_range(1, 6), 8'h00, 1'b0, hdr_len, pay_len);
                cut_stream(start, hdr_len + 1, 1'($urandom_range(0, 1)));
            end
        endcase

        // everything after the halt is ignored
        repeat (NOISE_ITEMS)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        logic quiet;
        sb = new();
        rst_n       <= 1'b0;
        rst_done    <= 1'b0;
        steady      <= 1'b0;
        in_valid    <= 1'b0;
        data_byte   <= '0;
        end_of_data <= 1'b0;
        build_stream();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n    <= 1'b1;
        rst_done <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stream_q.size(); i++)
        begin
            quiet = (i >= STEADY_FIRST && i < STEADY_LAST);
            steady <= quiet;
            while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            data_byte   <= stream_q[i][7:0];
            end_of_data <= stream_q[i][8];
            do
                @(posedge clk);
            while (!in_ready);
            sb.note_byte(stream_q[i][7:0], stream_q[i][8]);
        end
        in_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_done)
        begin
            if (out_valid && out_ready)
                sb.check_result({kind, byte_out, is_compressed, dict_reset, state_reset,
                                 props_present, unpacked_size, packed_size,
                                 literal_context_bits, literal_position_bits,
                                 position_bits, error_code});
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
        else
        begin
            out_ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
hw/rtl/lzcp_pkg.sv
hw/rtl/lzcp_props_dec.sv
hw/rtl/lzma2_chunk_header_parser.sv
hw/rtl/lzcp_checker.sv
dv/lzcp_scoreboard_pkg.sv
dv/tb_lzma2_chunk_header_parser.sv
